@@ design/sva_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Voice allocator package
// Shared types, codes and constants for the voice allocator and envelope block.
// ----------------------------------------------------------------------------
package sva_pkg;

	localparam int NUM_VOICES_DEF = 24;

	localparam int CMD_W   = 3;
	localparam int NOTE_W  = 7;
	localparam int LEVEL_W = 24;
	localparam int STAMP_W = 32;
	localparam int SLOT_W  = 5;
	localparam int COUNT_W = 5;
	localparam int ADDR_W  = 3;
	localparam int DATA_W  = 32;

	localparam logic [LEVEL_W-1:0] LEVEL_ONE  = 24'd8388608;
	localparam logic [LEVEL_W-1:0] LEVEL_CAP  = 24'd1006633;
	localparam logic [LEVEL_W-1:0] LEVEL_FREE = 24'd838;
	localparam logic [NOTE_W-1:0]  NOTE_RESET = 7'd60;

	localparam logic [LEVEL_W-1:0] ATTACK_RESET  = 24'd1000;
	localparam logic [LEVEL_W-1:0] RELEASE_RESET = 24'd100;

	// Register index, taken from paddr[2]
	localparam logic REG_ATTACK  = 1'b0;
	localparam logic REG_RELEASE = 1'b1;

	typedef enum logic [CMD_W-1:0] {
		CMD_NOTE_ON     = 3'd0,
		CMD_NOTE_OFF    = 3'd1,
		CMD_RELEASE_ALL = 3'd2,
		CMD_TICK        = 3'd3,
		CMD_ALL_OFF     = 3'd4
	} cmd_t;

	// One voice RAM word
	typedef struct packed {
		logic [NOTE_W-1:0]  note;
		logic [LEVEL_W-1:0] level;
		logic [STAMP_W-1:0] stamp;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// Request to the voice update unit
	typedef struct packed {
		logic [CMD_W-1:0]   cmd;
		logic [NOTE_W-1:0]  note;
		entry_t             ent;
		logic               act;
		logic               gate;
		logic [LEVEL_W-1:0] attack;
		logic [LEVEL_W-1:0] release_dec;
		logic [LEVEL_W-1:0] min_level;
		logic [STAMP_W-1:0] min_stamp;
		logic               first_elem;
	} vu_req_t;

	// Answer of the voice update unit
	typedef struct packed {
		entry_t ent;
		logic   act;
		logic   gate;
		logic   wr;
		logic   gate_clr;
		logic   better;
	} vu_rsp_t;

endpackage

@@ design/sva_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sva_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ design/sva_voice_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Voice update unit
// Shared envelope arithmetic, gate logic and steal compare for one voice.
// ----------------------------------------------------------------------------
module sva_voice_unit (
	input  sva_pkg::vu_req_t req,
	output sva_pkg::vu_rsp_t rsp
);

	import sva_pkg::*;

	logic [LEVEL_W:0]   sum;
	logic [LEVEL_W-1:0] up_level;
	logic [LEVEL_W-1:0] down_level;

	assign sum        = {1'b0, req.ent.level} + {1'b0, req.attack};
	assign up_level   = (sum > {1'b0, LEVEL_ONE}) ? LEVEL_ONE : sum[LEVEL_W-1:0];
	assign down_level = (req.ent.level > req.release_dec) ?
		req.ent.level - req.release_dec : '0;

	always_comb begin
		rsp          = '0;
		rsp.ent      = req.ent;
		rsp.act      = req.act;
		rsp.gate     = req.gate;
		// lowest level wins, older stamp breaks a tie
		rsp.better   = req.first_elem || (req.ent.level < req.min_level) ||
			((req.ent.level == req.min_level) && (req.ent.stamp < req.min_stamp));
		case (req.cmd)
			CMD_NOTE_OFF: begin
				if (req.act && (req.ent.note == req.note)) begin
					rsp.gate     = 1'b0;
					rsp.gate_clr = req.gate;
				end
			end
			CMD_RELEASE_ALL: begin
				rsp.gate     = 1'b0;
				rsp.gate_clr = req.gate;
			end
			CMD_TICK: begin
				rsp.wr = 1'b1;
				if (req.act) begin
					if (req.gate) begin
						rsp.ent.level = up_level;
					end else begin
						rsp.ent.level = down_level;
						if (down_level <= LEVEL_FREE) begin
							rsp.act = 1'b0;
						end
					end
				end
			end
			CMD_ALL_OFF: begin
				rsp.wr        = 1'b1;
				rsp.act       = 1'b0;
				rsp.gate      = 1'b0;
				rsp.ent.level = '0;
			end
			default: begin
			end
		endcase
	end

endmodule

@@ design/synth_voice_allocator_envelope.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Polyphonic voice allocator with linear envelopes
// Voice table with note on, note off, release all, tick and all off commands.
// ----------------------------------------------------------------------------
// Every command walks the whole voice table, one voice per cycle, through the
// voice RAM and one shared update unit, then passes a finish state before its
// result word appears; busy stays high from the accepting edge until the
// result word appears. The result word is held on the result ports for
// exactly one cycle with result_valid high; there is no way to stall it, so
// sample it when it shows. A new command may be started in that same cycle.
// Configuration registers: attack_increment at byte address 0,
// release_decrement at 4, 24 bits each; the user must write them only while
// busy is low and no result is pending. The block itself does not enforce it.
// ----------------------------------------------------------------------------
module synth_voice_allocator_envelope #(
	parameter int NUM_VOICES = sva_pkg::NUM_VOICES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// command channel
	input  logic                          start,
	output logic                          busy,
	input  logic [sva_pkg::CMD_W-1:0]     cmd,
	input  logic [sva_pkg::NOTE_W-1:0]    note_number,
	// result channel
	output logic                          result_valid,
	output logic [sva_pkg::SLOT_W-1:0]    voice_slot,
	output logic                          stolen,
	output logic [sva_pkg::COUNT_W-1:0]   gates_cleared,
	output logic [sva_pkg::COUNT_W-1:0]   active_voices,
	// configuration port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [sva_pkg::ADDR_W-1:0]    paddr,
	input  logic [sva_pkg::DATA_W-1:0]    pwdata,
	output logic [sva_pkg::DATA_W-1:0]    prdata,
	output logic                          pready
);

	import sva_pkg::*;

	localparam int IW  = $clog2(NUM_VOICES);
	localparam int CW  = $clog2(NUM_VOICES + 1);
	localparam int SEW = (IW > SLOT_W) ? IW : SLOT_W;
	localparam int CEW = (CW > COUNT_W) ? CW : COUNT_W;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	state_t state_q;

	// command word and pass control
	logic [CMD_W-1:0]   cmd_q;
	logic [NOTE_W-1:0]  note_q;
	logic [CW-1:0]      cnt_q;
	logic               vld_s1;
	logic [IW-1:0]      idx_s1;

	// per-voice flags
	logic [NUM_VOICES-1:0] active_q;
	logic [NUM_VOICES-1:0] gate_q;
	logic [NUM_VOICES-1:0] written_q;

	// pass accumulators
	logic [CW-1:0]      cleared_q;
	logic [CW-1:0]      count_q;
	logic               first_found_q;
	logic [IW-1:0]      first_idx_q;
	logic [LEVEL_W-1:0] first_level_q;
	logic [IW-1:0]      min_idx_q;
	logic [LEVEL_W-1:0] min_level_q;
	logic [STAMP_W-1:0] min_stamp_q;

	logic [STAMP_W-1:0] stamp_ctr_q;
	logic [LEVEL_W-1:0] attack_q;
	logic [LEVEL_W-1:0] release_q;

	// result word
	logic               result_valid_q;
	logic [SLOT_W-1:0]  voice_slot_q;
	logic               stolen_q;
	logic [COUNT_W-1:0] gates_cleared_q;
	logic [COUNT_W-1:0] active_voices_q;

	logic               accept;
	logic               issue;
	logic               last_s1;
	logic               cfg_wr;
	logic [ENTRY_W-1:0] rdata;
	entry_t             ent_s1;
	vu_req_t            vu_req;
	vu_rsp_t            vu_rsp;

	// note-on finish
	logic               is_note_on;
	logic               steal;
	logic [IW-1:0]      pick;
	logic [LEVEL_W-1:0] pick_level;
	logic [LEVEL_W-1:0] capped_level;
	logic [STAMP_W-1:0] stamp_next;
	entry_t             pick_ent;
	logic [CW-1:0]      count_final;
	logic [SEW-1:0]     slot_ext;
	logic [CEW-1:0]     count_ext;
	logic [CEW-1:0]     cleared_ext;

	// RAM port mux
	logic               ram_we;
	logic [IW-1:0]      ram_waddr;
	entry_t             ram_wdata;

	assign accept  = start && !busy;
	assign busy    = (state_q != ST_IDLE);
	assign issue   = (state_q == ST_RUN) && (cnt_q != CW'(NUM_VOICES));
	assign last_s1 = vld_s1 && (idx_s1 == IW'(NUM_VOICES - 1));

	// ------------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attack_q  <= ATTACK_RESET;
			release_q <= RELEASE_RESET;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_ATTACK:  attack_q  <= pwdata[LEVEL_W-1:0];
				REG_RELEASE: release_q <= pwdata[LEVEL_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_ATTACK:  prdata = {{(DATA_W-LEVEL_W){1'b0}}, attack_q};
			REG_RELEASE: prdata = {{(DATA_W-LEVEL_W){1'b0}}, release_q};
			default:     prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------------
	// Voice RAM: note, level and stamp of every voice. An entry never written
	// reads as its reset value (note 60, level and stamp zero).
	// ------------------------------------------------------------------------
	sva_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (NUM_VOICES)
	) u_voice_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (issue),
		.raddr (cnt_q[IW-1:0]),
		.rdata (rdata)
	);

	always_comb begin
		if (written_q[idx_s1]) begin
			ent_s1 = entry_t'(rdata);
		end else begin
			ent_s1.note  = NOTE_RESET;
			ent_s1.level = '0;
			ent_s1.stamp = '0;
		end
	end

	// ------------------------------------------------------------------------
	// Shared update unit, fed with the voice read in the previous cycle
	// ------------------------------------------------------------------------
	always_comb begin
		vu_req.cmd         = cmd_q;
		vu_req.note        = note_q;
		vu_req.ent         = ent_s1;
		vu_req.act         = active_q[idx_s1];
		vu_req.gate        = gate_q[idx_s1];
		vu_req.attack      = attack_q;
		vu_req.release_dec = release_q;
		vu_req.min_level   = min_level_q;
		vu_req.min_stamp   = min_stamp_q;
		vu_req.first_elem  = (idx_s1 == '0);
	end

	sva_voice_unit u_voice_unit (
		.req (vu_req),
		.rsp (vu_rsp)
	);

	// ------------------------------------------------------------------------
	// Note-on finish: first free voice, else the steal candidate. Cap its
	// level, give it the note and a fresh stamp.
	// ------------------------------------------------------------------------
	assign is_note_on   = (cmd_q == CMD_NOTE_ON);
	assign steal        = !first_found_q;
	assign pick         = steal ? min_idx_q : first_idx_q;
	assign pick_level   = steal ? min_level_q : first_level_q;
	assign capped_level = (pick_level > LEVEL_CAP) ? LEVEL_CAP : pick_level;
	assign stamp_next   = stamp_ctr_q + 1'b1;
	assign count_final  = (is_note_on && !steal) ? count_q + 1'b1 : count_q;

	always_comb begin
		pick_ent.note  = note_q;
		pick_ent.level = capped_level;
		pick_ent.stamp = stamp_next;
	end

	assign slot_ext    = SEW'(pick);
	assign count_ext   = CEW'(count_final);
	assign cleared_ext = CEW'(cleared_q);

	always_comb begin
		if (state_q == ST_DONE) begin
			ram_we    = is_note_on;
			ram_waddr = pick;
			ram_wdata = pick_ent;
		end else begin
			ram_we    = vld_s1 && vu_rsp.wr;
			ram_waddr = idx_s1;
			ram_wdata = vu_rsp.ent;
		end
	end

	// ------------------------------------------------------------------------
	// Sequencer and pass bookkeeping
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			cnt_q          <= '0;
			vld_s1         <= 1'b0;
			active_q       <= '0;
			gate_q         <= '0;
			written_q      <= '0;
			stamp_ctr_q    <= '0;
			result_valid_q <= 1'b0;
			first_found_q  <= 1'b0;
		end else begin
			result_valid_q <= 1'b0;
			vld_s1         <= issue;
			if (issue) begin
				cnt_q <= cnt_q + 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q       <= ST_RUN;
						cnt_q         <= '0;
						first_found_q <= 1'b0;
					end
				end
				ST_RUN: begin
					if (vld_s1) begin
						active_q[idx_s1] <= vu_rsp.act;
						gate_q[idx_s1]   <= vu_rsp.gate;
						if (vu_rsp.wr) begin
							written_q[idx_s1] <= 1'b1;
						end
						// first free voice for note on
						if (!vu_req.act && !first_found_q) begin
							first_found_q <= 1'b1;
						end
					end
					if (last_s1) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (is_note_on) begin
						active_q[pick]  <= 1'b1;
						gate_q[pick]    <= 1'b1;
						written_q[pick] <= 1'b1;
						stamp_ctr_q     <= stamp_next;
					end
					result_valid_q <= 1'b1;
					state_q        <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers: no reset
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q     <= cmd;
			note_q    <= note_number;
			cleared_q <= '0;
			count_q   <= '0;
		end
		if (issue) begin
			idx_s1 <= cnt_q[IW-1:0];
		end
		if ((state_q == ST_RUN) && vld_s1) begin
			cleared_q <= cleared_q + CW'(vu_rsp.gate_clr);
			count_q   <= count_q + CW'(vu_rsp.act);
			if (!vu_req.act && !first_found_q) begin
				first_idx_q   <= idx_s1;
				first_level_q <= ent_s1.level;
			end
			if (vu_rsp.better) begin
				min_idx_q   <= idx_s1;
				min_level_q <= ent_s1.level;
				min_stamp_q <= ent_s1.stamp;
			end
		end
		if (state_q == ST_DONE) begin
			voice_slot_q    <= is_note_on ? slot_ext[SLOT_W-1:0] : '0;
			stolen_q        <= is_note_on && steal;
			gates_cleared_q <= cleared_ext[COUNT_W-1:0];
			active_voices_q <= count_ext[COUNT_W-1:0];
		end
	end

	assign result_valid  = result_valid_q;
	assign voice_slot    = voice_slot_q;
	assign stolen        = stolen_q;
	assign gates_cleared = gates_cleared_q;
	assign active_voices = active_voices_q;

	// ------------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------------
	a_gate_implies_active: assert property (@(posedge clk) disable iff (!arst_n)
		(gate_q & ~active_q) == '0)
		else $error("gated voice is not active");

	a_result_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("result word shown for more than one cycle");

	a_accept_goes_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("accepted command did not raise busy");

	a_result_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) |=> (result_valid && !busy))
		else $error("finish did not produce a result word");

	a_steal_full_table: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_DONE) && is_note_on && steal) |-> (count_q == CW'(NUM_VOICES)))
		else $error("steal while a voice was free");

endmodule
